/* src/aabb_affine_transform_defines.svh */
// Assertion macros for the AABB affine transform block.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef AABB_AFFINE_TRANSFORM_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS
`define AAT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("aat: assertion failed");
`define AAT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("aat: assertion failed");
`else
`define AAT_ASSERT_NOW(label, ante, cons)
`define AAT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* src/aat_pkg.sv */
// Shared types and constants for the AABB affine transform block.
// No dependencies.
`default_nettype none

package aat_pkg;

	localparam int NUM_AXES  = 3;
	localparam int ROW_LEN   = 4;
	localparam int NUM_COEFS = NUM_AXES * ROW_LEN;
	localparam int COEF_W    = 32;
	localparam int IDX_W     = 4;

	typedef logic signed [COEF_W-1:0] q_t;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_BOX  = 1'b1;

	localparam q_t S32_MAX = 32'sh7FFF_FFFF;
	localparam q_t S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} stage_en_t;

	typedef struct packed {
		q_t   out_min_x;
		q_t   out_min_y;
		q_t   out_min_z;
		q_t   out_max_x;
		q_t   out_max_y;
		q_t   out_max_z;
		logic box_valid;
	} res_t;

endpackage

`default_nettype wire

/* src/aat_req_if.sv */
// Request channel of the AABB affine transform block: coefficient loads and boxes.
// No dependencies.
`default_nettype none

interface aat_req_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [3:0]         coef_index;
	logic signed [31:0] coef_value;
	logic signed [31:0] min_x;
	logic signed [31:0] min_y;
	logic signed [31:0] min_z;
	logic signed [31:0] max_x;
	logic signed [31:0] max_y;
	logic signed [31:0] max_z;

	modport source (
		output valid, mode, coef_index, coef_value, min_x, min_y, min_z, max_x, max_y, max_z,
		input  ready
	);
	modport sink (
		input  valid, mode, coef_index, coef_value, min_x, min_y, min_z, max_x, max_y, max_z,
		output ready
	);
endinterface

`default_nettype wire

/* src/aat_rsp_if.sv */
// Result channel of the AABB affine transform block: transformed boxes.
// No dependencies.
`default_nettype none

interface aat_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_min_x;
	logic signed [31:0] out_min_y;
	logic signed [31:0] out_min_z;
	logic signed [31:0] out_max_x;
	logic signed [31:0] out_max_y;
	logic signed [31:0] out_max_z;
	logic               box_valid;

	modport source (
		output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
		output box_valid,
		input  ready
	);
	modport sink (
		input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
		input  box_valid,
		output ready
	);
endinterface

`default_nettype wire

/* src/aat_lane.sv */
// One output-axis lane: products, per-term min/max, and the two axis sums.
// Depends on aat_pkg.
`default_nettype none

module aat_lane import aat_pkg::*; #(
	parameter  int FRAC_BITS = 16,
	localparam int PROD_W    = 2 * COEF_W,
	localparam int FLR_W     = PROD_W - FRAC_BITS,
	localparam int SUM_W     = FLR_W + 2
) (
	input  logic                    clk,
	input  stage_en_t               en,
	input  q_t                      weight [NUM_AXES],
	input  q_t                      offset,
	input  q_t                      lo     [NUM_AXES],
	input  q_t                      hi     [NUM_AXES],
	output logic signed [SUM_W-1:0] sum_min,
	output logic signed [SUM_W-1:0] sum_max
);

	logic signed [PROD_W-1:0] prod_lo_s1 [NUM_AXES];
	logic signed [PROD_W-1:0] prod_hi_s1 [NUM_AXES];
	q_t                       offset_s1;
	logic signed [FLR_W-1:0]  flr_lo     [NUM_AXES];
	logic signed [FLR_W-1:0]  flr_hi     [NUM_AXES];
	logic signed [FLR_W-1:0]  min_s2     [NUM_AXES];
	logic signed [FLR_W-1:0]  max_s2     [NUM_AXES];
	q_t                       offset_s2;
	logic signed [SUM_W-1:0]  sum_min_s3;
	logic signed [SUM_W-1:0]  sum_max_s3;

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				prod_lo_s1[k] <= PROD_W'(weight[k]) * PROD_W'(lo[k]);
				prod_hi_s1[k] <= PROD_W'(weight[k]) * PROD_W'(hi[k]);
			end
			offset_s1 <= offset;
		end
	end

	// arithmetic drop of the fraction bits floors toward minus infinity
	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			flr_lo[k] = prod_lo_s1[k][PROD_W-1:FRAC_BITS];
			flr_hi[k] = prod_hi_s1[k][PROD_W-1:FRAC_BITS];
		end
	end

	// each term is monotone in its coordinate, so the extremes split per term
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				if (flr_lo[k] <= flr_hi[k]) begin
					min_s2[k] <= flr_lo[k];
					max_s2[k] <= flr_hi[k];
				end else begin
					min_s2[k] <= flr_hi[k];
					max_s2[k] <= flr_lo[k];
				end
			end
			offset_s2 <= offset_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			sum_min_s3 <= SUM_W'(min_s2[0]) + SUM_W'(min_s2[1]) + SUM_W'(min_s2[2])
				+ SUM_W'(offset_s2);
			sum_max_s3 <= SUM_W'(max_s2[0]) + SUM_W'(max_s2[1]) + SUM_W'(max_s2[2])
				+ SUM_W'(offset_s2);
		end
	end

	assign sum_min = sum_min_s3;
	assign sum_max = sum_max_s3;

endmodule

`default_nettype wire

/* src/aat_merge.sv */
// Merge stage: saturates the lane sums, substitutes the empty box, holds the result.
// Depends on aat_pkg.
`default_nettype none

module aat_merge import aat_pkg::*; #(
	parameter  int FRAC_BITS = 16,
	localparam int SUM_W     = 2 * COEF_W - FRAC_BITS + 2
) (
	input  logic                    clk,
	input  logic                    en_out,
	input  logic                    box_ok,
	input  logic signed [SUM_W-1:0] sum_min [NUM_AXES],
	input  logic signed [SUM_W-1:0] sum_max [NUM_AXES],
	output res_t                    res
);

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(S32_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(S32_MIN);

	q_t   mn [NUM_AXES];
	q_t   mx [NUM_AXES];
	res_t res_q;

	function automatic q_t sat32(input logic signed [SUM_W-1:0] v);
		q_t r;
		if (v > SAT_HI) begin
			r = S32_MAX;
		end else if (v < SAT_LO) begin
			r = S32_MIN;
		end else begin
			r = v[COEF_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			if (box_ok) begin
				mn[a] = sat32(sum_min[a]);
				mx[a] = sat32(sum_max[a]);
			end else begin
				mn[a] = S32_MAX;
				mx[a] = S32_MIN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			res_q.out_min_x <= mn[0];
			res_q.out_min_y <= mn[1];
			res_q.out_min_z <= mn[2];
			res_q.out_max_x <= mx[0];
			res_q.out_max_y <= mx[1];
			res_q.out_max_z <= mx[2];
			res_q.box_valid <= box_ok;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

/* src/aabb_affine_transform.sv */
// Top level of the AABB affine transform block: coefficient store, pipeline control,
// three axis lanes and the merge stage. Depends on aat_pkg, the channel interfaces,
// aat_lane, aat_merge and the assertion macro header.
`default_nettype none

`include "aabb_affine_transform_defines.svh"

// A request with mode 0 writes one Q16.16 coefficient of the 3x4 matrix (slots 12..15
// are dropped, no result); with mode 1 it carries a box and yields one result: the
// enclosing box of its eight transformed corners, or the empty box with box_valid low
// when min exceeds max on an axis. One request is taken per cycle while the result
// channel is not stalled; a box result passes four register stages (multiply at the
// accepting edge, term min/max, sum, saturate) built around 18 parallel 32x32
// multipliers. A load takes effect for boxes accepted after it. Reset restores
// the identity matrix.
module aabb_affine_transform import aat_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	aat_req_if.sink   req,
	aat_rsp_if.source rsp
);

	localparam int       SUM_W = 2 * COEF_W - FRAC_BITS + 2;
	localparam logic [COEF_W-1:0] ONE = COEF_W'(64'd1 << FRAC_BITS);

	q_t        matrix_q [NUM_COEFS];
	q_t        wgt      [NUM_AXES][NUM_AXES];
	q_t        offs     [NUM_AXES];
	q_t        lo       [NUM_AXES];
	q_t        hi       [NUM_AXES];
	logic signed [SUM_W-1:0] smin [NUM_AXES];
	logic signed [SUM_W-1:0] smax [NUM_AXES];

	logic      v_s1, v_s2, v_s3, out_v_q;
	logic      ok_s1, ok_s2, ok_s3;
	logic      en_out;
	stage_en_t en;
	logic      acc, box_acc, bad;
	res_t      res;
	logic      empty_ok, order_ok, ld_slot0;

	assign en_out   = !out_v_q || rsp.ready;
	assign en.en_s3 = !v_s3 || en_out;
	assign en.en_s2 = !v_s2 || en.en_s3;
	assign en.en_s1 = !v_s1 || en.en_s2;

	assign req.ready = en.en_s1;
	assign acc       = req.valid && req.ready;
	assign box_acc   = acc && (req.mode == MODE_BOX);
	assign bad       = (req.min_x > req.max_x) || (req.min_y > req.max_y)
		|| (req.min_z > req.max_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				matrix_q[i] <= (i % (ROW_LEN + 1) == 0) ? ONE : '0;
			end
		end else if (acc && (req.mode == MODE_LOAD) && (req.coef_index < IDX_W'(NUM_COEFS))) begin
			matrix_q[req.coef_index] <= req.coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en.en_s1) v_s1 <= box_acc;
			if (en.en_s2) v_s2 <= v_s1;
			if (en.en_s3) v_s3 <= v_s2;
			if (en_out)   out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) ok_s1 <= !bad;
		if (en.en_s2) ok_s2 <= ok_s1;
		if (en.en_s3) ok_s3 <= ok_s2;
	end

	assign lo[0] = req.min_x;
	assign lo[1] = req.min_y;
	assign lo[2] = req.min_z;
	assign hi[0] = req.max_x;
	assign hi[1] = req.max_y;
	assign hi[2] = req.max_z;

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		for (genvar k = 0; k < NUM_AXES; k++) begin : g_w
			assign wgt[a][k] = matrix_q[a * ROW_LEN + k];
		end
		assign offs[a] = matrix_q[a * ROW_LEN + NUM_AXES];

		aat_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk     (clk),
			.en      (en),
			.weight  (wgt[a]),
			.offset  (offs[a]),
			.lo      (lo),
			.hi      (hi),
			.sum_min (smin[a]),
			.sum_max (smax[a])
		);
	end

	aat_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
		.clk     (clk),
		.en_out  (en_out),
		.box_ok  (ok_s3),
		.sum_min (smin),
		.sum_max (smax),
		.res     (res)
	);

	assign rsp.valid     = out_v_q;
	assign rsp.out_min_x = res.out_min_x;
	assign rsp.out_min_y = res.out_min_y;
	assign rsp.out_min_z = res.out_min_z;
	assign rsp.out_max_x = res.out_max_x;
	assign rsp.out_max_y = res.out_max_y;
	assign rsp.out_max_z = res.out_max_z;
	assign rsp.box_valid = res.box_valid;

	assign empty_ok = rsp.out_min_x == S32_MAX && rsp.out_min_y == S32_MAX
		&& rsp.out_min_z == S32_MAX && rsp.out_max_x == S32_MIN
		&& rsp.out_max_y == S32_MIN && rsp.out_max_z == S32_MIN;
	assign order_ok = rsp.out_min_x <= rsp.out_max_x && rsp.out_min_y <= rsp.out_max_y
		&& rsp.out_min_z <= rsp.out_max_z;
	assign ld_slot0 = acc && req.mode == MODE_LOAD && req.coef_index == '0;

	`AAT_ASSERT_NOW(a_empty_box, rsp.valid && !rsp.box_valid, empty_ok)
	`AAT_ASSERT_NOW(a_box_order, rsp.valid && rsp.box_valid, order_ok)
	`AAT_ASSERT_NEXT(a_coef_load, ld_slot0, matrix_q[0] == $past(req.coef_value))

endmodule

`default_nettype wire

/* test/aat_box_checker.sv */
// Checker for the AABB affine transform block: tracks the coefficient matrix, predicts
// each transformed box and compares it with the result channel.
// Depends on aat_pkg, aat_req_if and aat_rsp_if.
module aat_box_checker import aat_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	aat_req_if   req,
	aat_rsp_if   rsp,
	output int   pending,
	output int   fail_count
);

	q_t   coefs [NUM_COEFS];
	res_t expected_boxes [$];

	// floor each product to FRAC_BITS, add translation, saturate
	function automatic longint map_row(input int row, input longint p [NUM_AXES]);
		longint acc;
		acc = coefs[row*ROW_LEN + NUM_AXES];
		for (int k = 0; k < NUM_AXES; k++)
			acc += (longint'(coefs[row*ROW_LEN + k]) * p[k]) >>> FRAC_BITS;
		if (acc > longint'(S32_MAX))
			acc = S32_MAX;
		else if (acc < longint'(S32_MIN))
			acc = S32_MIN;
		return acc;
	endfunction

	function automatic res_t enclosing_box(input q_t lo [NUM_AXES], input q_t hi [NUM_AXES]);
		res_t   r;
		longint p [NUM_AXES];
		longint mn [NUM_AXES];
		longint mx [NUM_AXES];
		longint v;
		logic   ok;
		ok = 1'b1;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (lo[a] > hi[a])
				ok = 1'b0;
			mn[a] = S32_MAX;
			mx[a] = S32_MIN;
		end
		if (ok) begin
			for (int c = 0; c < 8; c++) begin
				for (int a = 0; a < NUM_AXES; a++)
					p[a] = ((c >> a) & 1) ? hi[a] : lo[a];
				for (int a = 0; a < NUM_AXES; a++) begin
					v = map_row(a, p);
					if (v < mn[a])
						mn[a] = v;
					if (v > mx[a])
						mx[a] = v;
				end
			end
		end
		r.out_min_x = q_t'(mn[0]);
		r.out_min_y = q_t'(mn[1]);
		r.out_min_z = q_t'(mn[2]);
		r.out_max_x = q_t'(mx[0]);
		r.out_max_y = q_t'(mx[1]);
		r.out_max_z = q_t'(mx[2]);
		r.box_valid = ok;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		res_t want;
		res_t got;
		q_t   lo_pt [NUM_AXES];
		q_t   hi_pt [NUM_AXES];
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++)
				coefs[i] = '0;
			for (int a = 0; a < NUM_AXES; a++)
				coefs[a*ROW_LEN + a] = q_t'(1 << FRAC_BITS);
			expected_boxes.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.out_min_x, rsp.out_min_y, rsp.out_min_z,
					rsp.out_max_x, rsp.out_max_y, rsp.out_max_z, rsp.box_valid};
				if (expected_boxes.size() == 0) begin
					$display("%0t unexpected result: expected none actual %h", $time, got);
					fail_count++;
				end else begin
					want = expected_boxes.pop_front();
					check_field("out_min_x", want.out_min_x, got.out_min_x);
					check_field("out_min_y", want.out_min_y, got.out_min_y);
					check_field("out_min_z", want.out_min_z, got.out_min_z);
					check_field("out_max_x", want.out_max_x, got.out_max_x);
					check_field("out_max_y", want.out_max_y, got.out_max_y);
					check_field("out_max_z", want.out_max_z, got.out_max_z);
					check_field("box_valid", want.box_valid, got.box_valid);
				end
			end
			if (req.valid && req.ready) begin
				if (req.mode == MODE_LOAD) begin
					if (req.coef_index < NUM_COEFS)
						coefs[req.coef_index] = req.coef_value;
				end else begin
					lo_pt[0] = req.min_x;
					lo_pt[1] = req.min_y;
					lo_pt[2] = req.min_z;
					hi_pt[0] = req.max_x;
					hi_pt[1] = req.max_y;
					hi_pt[2] = req.max_z;
					expected_boxes.push_back(enclosing_box(lo_pt, hi_pt));
				end
			end
			pending = expected_boxes.size();
		end
	end

endmodule

/* test/tb.sv */
// Testbench top for the AABB affine transform block: clock, reset, request stimulus
// and result back-pressure; checking is done by aat_box_checker.
// Depends on aat_pkg, aat_req_if, aat_rsp_if, aabb_affine_transform and aat_box_checker.
module tb;
	import aat_pkg::*;

	localparam int CLK_HALF        = 6;
	localparam int FRAC_BITS       = 16;
	localparam int RANDOM_ITEMS    = 850;
	localparam int HOLD_AT         = 300;
	localparam int HOLD_BURST      = 40;
	localparam int RSP_HOLD_CYCLES = 80;
	localparam int PAUSE_AT        = 550;
	localparam int STEADY_FROM     = 750;
	localparam int DRAIN_CYCLES    = 20;
	localparam int TIMEOUT_CYCLES  = 200000;

	localparam q_t Q_ONE     = 32'sh0001_0000;
	localparam q_t Q_NEG_ONE = 32'shFFFF_0000;
	localparam q_t SWAP_MATRIX [NUM_COEFS] = '{
		32'sh0, Q_NEG_ONE, 32'sh0, 32'sh000A_8000,
		Q_ONE, 32'sh0, 32'sh0, 32'shFFFC_C000,
		32'sh0, 32'sh0, 32'shFFFF_8000, S32_MIN
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   pending;
	int   fail_count;
	bit   steady = 1'b0;
	bit   hold_asked = 1'b0;
	bit   hold_served = 1'b0;

	aat_req_if req_ch ();
	aat_rsp_if rsp_ch ();

	aabb_affine_transform #(.FRAC_BITS(FRAC_BITS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	aat_box_checker #(.FRAC_BITS(FRAC_BITS)) box_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #CLK_HALF clk = ~clk;

	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("FAIL aabb_affine_transform");
		$finish;
	end

	function automatic q_t rand_coord();
		case ($urandom_range(0, 9))
			0: return S32_MAX;
			1: return S32_MIN;
			2, 3: return q_t'($urandom);
			default: return q_t'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
		endcase
	endfunction

	function automatic q_t rand_coef();
		case ($urandom_range(0, 9))
			0: return S32_MAX;
			1: return S32_MIN;
			2: return '0;
			3: return q_t'($urandom);
			default: return q_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	task automatic offer(input logic mode, input logic [3:0] idx, input q_t coef,
		input q_t lo [NUM_AXES], input q_t hi [NUM_AXES]);
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= mode;
		req_ch.coef_index <= idx;
		req_ch.coef_value <= coef;
		req_ch.min_x      <= lo[0];
		req_ch.min_y      <= lo[1];
		req_ch.min_z      <= lo[2];
		req_ch.max_x      <= hi[0];
		req_ch.max_y      <= hi[1];
		req_ch.max_z      <= hi[2];
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic load_coef(input logic [3:0] idx, input q_t value);
		q_t junk_lo [NUM_AXES];
		q_t junk_hi [NUM_AXES];
		for (int a = 0; a < NUM_AXES; a++) begin
			junk_lo[a] = q_t'($urandom);
			junk_hi[a] = q_t'($urandom);
		end
		offer(MODE_LOAD, idx, value, junk_lo, junk_hi);
	endtask

	task automatic send_box(input q_t lx, input q_t ly, input q_t lz,
		input q_t hx, input q_t hy, input q_t hz);
		q_t lo [NUM_AXES];
		q_t hi [NUM_AXES];
		lo[0] = lx;
		lo[1] = ly;
		lo[2] = lz;
		hi[0] = hx;
		hi[1] = hy;
		hi[2] = hz;
		offer(MODE_BOX, 4'($urandom), q_t'($urandom), lo, hi);
	endtask

	// result side: random stalls, one long hold-off on request, steady at the end
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_asked && !hold_served) begin
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
				hold_served = 1'b1;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat (steady ? 1 : $urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		q_t lo [NUM_AXES];
		q_t hi [NUM_AXES];
		q_t pa;
		q_t pb;
		int ax;
		int burst_left;
		burst_left = 0;
		req_ch.valid      <= 1'b0;
		req_ch.mode       <= MODE_LOAD;
		req_ch.coef_index <= '0;
		req_ch.coef_value <= '0;
		req_ch.min_x      <= '0;
		req_ch.min_y      <= '0;
		req_ch.min_z      <= '0;
		req_ch.max_x      <= '0;
		req_ch.max_y      <= '0;
		req_ch.max_z      <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity matrix after reset
		send_box(32'shFFFE_8000, 32'sh0002_0000, 32'sh0, 32'sh0003_0000, 32'sh0002_0000,
			32'sh0064_0000);
		send_box(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX);
		// empty box, one axis inverted at a time
		send_box(Q_ONE, 32'sh0, 32'sh0, 32'sh0, Q_ONE, Q_ONE);
		send_box(32'sh0, Q_ONE, 32'sh0, Q_ONE, 32'sh0, Q_ONE);
		send_box(32'sh0, 32'sh0, S32_MAX, Q_ONE, Q_ONE, S32_MIN);
		// slots past the matrix are dropped
		load_coef(4'd12, 32'sh0);
		load_coef(4'd15, S32_MAX);
		send_box(-32'sh1, -32'sh1, -32'sh1, 32'sh1, 32'sh1, 32'sh1);
		for (int i = 0; i < NUM_COEFS; i++)
			load_coef(4'(i), SWAP_MATRIX[i]);
		send_box(32'shFFFE_8000, 32'sh0002_0000, 32'sh0, 32'sh0003_0000, 32'sh0002_0000,
			32'sh0064_0000);
		// saturation both ways
		load_coef(4'd0, S32_MAX);
		load_coef(4'd1, S32_MIN);
		load_coef(4'd3, S32_MAX);
		send_box(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX);
		send_box(-32'sh1, -32'sh1, -32'sh1, 32'sh1, 32'sh1, 32'sh1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= STEADY_FROM);
			if (n == HOLD_AT) begin
				hold_asked = 1'b1;
				burst_left = HOLD_BURST;
			end
			if (n == PAUSE_AT) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			if (burst_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			if (burst_left == 0 && $urandom_range(0, 4) == 0) begin
				load_coef(4'($urandom_range(0, 15)), rand_coef());
			end else begin
				for (int a = 0; a < NUM_AXES; a++) begin
					pa = rand_coord();
					pb = ($urandom_range(0, 7) == 0) ? pa : rand_coord();
					lo[a] = (pa < pb) ? pa : pb;
					hi[a] = (pa < pb) ? pb : pa;
				end
				if ($urandom_range(0, 9) == 0) begin
					ax = $urandom_range(0, NUM_AXES - 1);
					pa = lo[ax];
					lo[ax] = hi[ax];
					hi[ax] = pa;
					if (lo[ax] == hi[ax]) begin
						if (hi[ax] == S32_MAX)
							hi[ax] = hi[ax] - 1;
						else
							lo[ax] = lo[ax] + 1;
					end
				end
				offer(MODE_BOX, 4'($urandom), q_t'($urandom), lo, hi);
				if (burst_left > 0)
					burst_left--;
			end
		end

		req_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS aabb_affine_transform");
		else
			$display("FAIL aabb_affine_transform");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/aat_pkg.sv
src/aat_req_if.sv
src/aat_rsp_if.sv
src/aat_lane.sv
src/aat_merge.sv
src/aabb_affine_transform.sv
test/aat_box_checker.sv
test/tb.sv
